// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/b64d_pkg.sv =====
// Package with constants, types and codes of the base64url stream decoder.
package b64d_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_BITS       = 16;
    localparam int RES_MAX        = 3;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd2048;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_62         = 6'd62;
    localparam logic [5:0] SEXTET_63         = 6'd63;

    localparam logic ACT_CHAR   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_OVF  = 2'd2;

    typedef logic [5:0] sextet_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_count;
        logic        last_of_run;
    } res_t;

    typedef struct packed {
        res_t [RES_MAX-1:0] item;
        logic [1:0]         num;
    } res_set_t;

endpackage

// ===== src/b64d_char_map.sv =====
// Character to sextet decoder for the standard and url-safe alphabets.
module b64d_char_map
    import b64d_pkg::*;
(
    input  logic [7:0] char_i,
    output logic       hit,
    output sextet_t    sextet
);

    logic [7:0] diff;

    always_comb begin
        hit    = 1'b1;
        sextet = '0;
        diff   = '0;
        if (char_i >= CHAR_UPPER_A && char_i <= CHAR_UPPER_Z) begin
            diff   = char_i - CHAR_UPPER_A;
            sextet = diff[5:0];
        end else if (char_i >= CHAR_LOWER_A && char_i <= CHAR_LOWER_Z) begin
            diff   = char_i - CHAR_LOWER_A;
            sextet = diff[5:0] + SEXTET_LOWER_BASE;
        end else if (char_i >= CHAR_DIGIT_0 && char_i <= CHAR_DIGIT_9) begin
            diff   = char_i - CHAR_DIGIT_0;
            sextet = diff[5:0] + SEXTET_DIGIT_BASE;
        end else if (char_i == CHAR_PLUS || char_i == CHAR_MINUS) begin
            sextet = SEXTET_62;
        end else if (char_i == CHAR_SLASH || char_i == CHAR_UNDER) begin
            sextet = SEXTET_63;
        end else begin
            hit = 1'b0;
        end
    end

endmodule

// ===== src/b64d_core.sv =====
// Input register, decode state and per-transaction result computation.
module b64d_core
    import b64d_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  logic [7:0]          s_tdata,
    input  logic                cfg_wr_en,
    input  logic [CAP_BITS-1:0] cfg_wr_data,
    input  logic                buf_free,
    output logic                load,
    output res_set_t            res_set
);

    localparam int CW = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 2;

    logic                  in_vld_reg;
    logic                  in_act_reg;
    logic [7:0]            in_char_reg;
    logic [CAP_BITS-1:0]   cap_reg;
    sextet_t               sextet_reg [RES_MAX];
    sextet_t               sextet_next [RES_MAX];
    logic [1:0]            fill_reg, fill_next;
    logic [COUNT_BITS-1:0] wc_reg, wc_next;
    logic                  ovf_reg, ovf_next;

    logic                  hit;
    sextet_t               val;
    logic [CW-1:0]         wc_ext, cap_ext;
    logic [COUNT_BITS-1:0] wcp1, wcp2, wcp3, wc1, wc2;
    logic                  e1, e2;
    res_t                  st;
    logic [7:0]            g0, g1, g2;

    function automatic logic [15:0] to_bc(input logic [COUNT_BITS-1:0] c);
        logic [CW-1:0] e;
        e = CW'(c);
        return e[15:0];
    endfunction

    b64d_char_map u_map (
        .char_i (in_char_reg),
        .hit    (hit),
        .sextet (val)
    );

    assign s_tready = !in_vld_reg || buf_free;
    assign load     = in_vld_reg && buf_free;

    always_comb begin
        wc_ext  = CW'(wc_reg);
        cap_ext = CW'(cap_reg);
        wcp1    = wc_reg + COUNT_BITS'(1);
        wcp2    = wc_reg + COUNT_BITS'(2);
        wcp3    = wc_reg + COUNT_BITS'(3);
        g0      = {sextet_reg[0], sextet_reg[1][5:4]};
        g1      = {sextet_reg[1][3:0], sextet_reg[2][5:2]};
        g2      = {sextet_reg[2][1:0], val};

        e1  = !ovf_reg && fill_reg >= 2'd2 && (wc_ext + CW'(1)) <= cap_ext;
        wc1 = e1 ? wcp1 : wc_reg;
        e2  = !ovf_reg && fill_reg == 2'd3 && (CW'(wc1) + CW'(1)) <= cap_ext;
        wc2 = e2 ? wcp2 : wc1;

        st.kind        = ovf_reg ? KIND_OVF : KIND_OK;
        st.data_byte   = '0;
        st.byte_count  = to_bc(wc2);
        st.last_of_run = 1'b1;

        fill_next   = fill_reg;
        sextet_next = sextet_reg;
        wc_next     = wc_reg;
        ovf_next    = ovf_reg;
        res_set     = '0;

        if (load) begin
            if (in_act_reg == ACT_CHAR) begin
                if (!ovf_reg && hit) begin
                    if (fill_reg != 2'd3) begin
                        sextet_next[fill_reg] = val;
                        fill_next             = fill_reg + 2'd1;
                    end else begin
                        fill_next = '0;
                        if ((wc_ext + CW'(3)) > cap_ext) begin
                            ovf_next = 1'b1;
                        end else begin
                            wc_next     = wcp3;
                            res_set.num = 2'd3;
                            res_set.item[0] = '{KIND_DATA, g0, to_bc(wcp1), 1'b0};
                            res_set.item[1] = '{KIND_DATA, g1, to_bc(wcp2), 1'b0};
                            res_set.item[2] = '{KIND_DATA, g2, to_bc(wcp3), 1'b1};
                        end
                    end
                end
            end else begin
                res_set.num     = 2'd1 + {1'b0, e1} + {1'b0, e2};
                res_set.item[0] = e1 ? '{KIND_DATA, g0, to_bc(wcp1), 1'b0} : st;
                res_set.item[1] = e2 ? '{KIND_DATA, g1, to_bc(wcp2), 1'b0} : st;
                res_set.item[2] = st;
                fill_next       = '0;
                wc_next         = '0;
                ovf_next        = 1'b0;
                for (int i = 0; i < RES_MAX; i++) begin
                    sextet_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            cap_reg    <= CAP_RESET;
            fill_reg   <= '0;
            wc_reg     <= '0;
            ovf_reg    <= 1'b0;
            for (int i = 0; i < RES_MAX; i++) begin
                sextet_reg[i] <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (load) begin
                in_vld_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            fill_reg   <= fill_next;
            wc_reg     <= wc_next;
            ovf_reg    <= ovf_next;
            sextet_reg <= sextet_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_act_reg  <= s_tuser;
            in_char_reg <= s_tdata;
        end
    end

endmodule

// ===== src/b64d_out_buf.sv =====
// Result register that hands out up to three results, one per transaction.
module b64d_out_buf
    import b64d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  res_set_t    res_set,
    output logic        buf_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    res_t [RES_MAX-1:0] items_reg;
    logic [1:0]         cnt_reg;
    logic [1:0]         idx_reg;
    res_t               cur;
    logic               pop;

    assign cur      = items_reg[idx_reg];
    assign m_tvalid = cnt_reg != 2'd0;
    assign pop      = m_tvalid && m_tready;
    assign buf_free = !m_tvalid || (pop && cnt_reg == 2'd1);
    assign m_tuser  = cur.kind;
    assign m_tdata  = {cur.byte_count, cur.data_byte};
    assign m_tlast  = cur.last_of_run;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= res_set.num;
            idx_reg <= '0;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            items_reg <= res_set.item;
        end
    end

endmodule

// ===== src/base64url_stream_decoder.sv =====
// Top level of the base64 / base64url stream decoder.
// Input: one transaction per character on s_*; s_tuser = 0 carries a character
// in s_tdata, s_tuser = 1 ends the string (flush partial group, report status).
// Output: one transaction per result on m_*; m_tuser is the kind (data byte,
// status ok, status overflow), m_tdata holds the byte and the running count,
// m_tlast marks the last result caused by one input transaction.
// The capacity register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, since the block itself does not enforce this.
// A result passes through the input register, then the result register. One
// input transaction per cycle is taken as long as each leaves at most one result
// and the receiver is ready; a completed group or a flush holds the input until
// the result register has handed out all its results, one result per cycle.
// Reset clears the decode state and the byte count, sets the capacity to 2048
// and empties both registers. When the receiver stalls, the current result
// holds and the input side stops once the input register is also full.
module base64url_stream_decoder
    import b64d_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,     // [0] action
    input  logic [7:0]          s_tdata,     // [7:0] in_char
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [1:0]          m_tuser,     // [1:0] kind
    output logic [23:0]         m_tdata,     // [7:0] data_byte, [23:8] byte_count
    output logic                m_tlast,
    input  logic                cfg_wr_en,
    input  logic [CAP_BITS-1:0] cfg_wr_data
);

`include "assert_macros.svh"

    logic     buf_free;
    logic     load;
    res_set_t res_set;

    b64d_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .buf_free    (buf_free),
        .load        (load),
        .res_set     (res_set)
    );

    b64d_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res_set  (res_set),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `ASSERT_CLKD(a_last_is_status, aclk, aresetn,
        (m_tvalid && m_tuser != KIND_DATA) |-> m_tlast, "status without last flag")
    `ASSERT_CLKD(a_status_zero_byte, aclk, aresetn,
        (m_tvalid && m_tuser != KIND_DATA) |-> (m_tdata[7:0] == 8'd0), "status with nonzero byte")
    `ASSERT_CLKD(a_kind_legal, aclk, aresetn,
        m_tvalid |-> (m_tuser == KIND_DATA || m_tuser == KIND_OK || m_tuser == KIND_OVF),
        "illegal kind code")
    `ASSERT_CLKD(a_load_needs_room, aclk, aresetn,
        load |-> buf_free, "result set loaded over pending results")

endmodule
